// ----- src/fsld_pkg.sv -----
package fsld_pkg;

  // History ring geometry.
  localparam int HIST_DEPTH = 16;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int TIME_W   = 32;
  localparam int ERR_W    = 8;
  localparam int LVL_W    = 2;
  localparam int CNT_OUT_W = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Levels.
  localparam logic [LVL_W-1:0] LVL_ABOVE_HALF = 2'd0;
  localparam logic [LVL_W-1:0] LVL_BELOW_HALF = 2'd1;
  localparam logic [LVL_W-1:0] LVL_NEAR_EMPTY = 2'd2;
  localparam logic [LVL_W-1:0] LVL_ERROR      = 2'd3;

  // Operations carried in in_tuser.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0]      RST_READ_INTERVAL = 16'd100;
  localparam logic [15:0]      RST_DEBOUNCE      = 16'd500;
  localparam logic [ERR_W-1:0] RST_ERROR_LIMIT   = 8'd3;
  localparam logic [ERR_W-1:0] ERR_SAT           = 8'd255;

  typedef struct packed {
    logic capture;
    logic update;
    logic walk_rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic walk_skip;
    logic walk_last;
  } sts_t;

  function automatic logic [LVL_W-1:0] map_level(input logic half, input logic empty);
    logic [LVL_W-1:0] lvl;
    if (half && empty) begin
      lvl = LVL_ABOVE_HALF;
    end else if (!half && empty) begin
      lvl = LVL_BELOW_HALF;
    end else if (!half && !empty) begin
      lvl = LVL_NEAR_EMPTY;
    end else begin
      lvl = LVL_ERROR;
    end
    return lvl;
  endfunction

endpackage

// ----- src/fsld_ram.sv -----
module fsld_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/fsld_ctrl.sv -----
module fsld_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  fsld_pkg::sts_t sts,
  output fsld_pkg::cmd_t cmd
);

  import fsld_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_UPD   = 5'b00010,
    S_WALK  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_LOAD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_skip) begin
          state_nxt = S_LOAD;
        end else begin
          cmd.walk_rd = 1'b1;
          if (sts.walk_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/fsld_dp.sv -----
module fsld_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fsld_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  output logic [fsld_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  input  logic [fsld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsld_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fsld_pkg::cmd_t                      cmd,
  output fsld_pkg::sts_t                      sts
);

  import fsld_pkg::*;

  // Configuration registers.
  logic [15:0]      interval_r;
  logic [15:0]      debounce_r;
  logic [ERR_W-1:0] limit_r;

  // Captured input item.
  logic              op_r;
  logic [TIME_W-1:0] now_r;
  logic              half_r;
  logic              empty_r;

  // Level tracking state.
  logic [LVL_W-1:0]   committed_r, committed_nxt;
  logic [LVL_W-1:0]   pend_lvl_r, pend_lvl_nxt;
  logic               pend_r, pend_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic               rec_r, rec_nxt;
  logic [TIME_W-1:0]  last_t_r, last_t_nxt;
  logic [TIME_W-1:0]  pend_t_r, pend_t_nxt;
  logic [HIST_AW-1:0] head_r, head_nxt;
  logic [HIST_CW-1:0] count_r, count_nxt;
  logic [LVL_W-1:0]   slot0_r;

  // Per-item flags and the stability walk.
  logic               changed_r, changed_nxt;
  logic               taken_r, taken_nxt;
  logic               valid_r, valid_nxt;
  logic               push;
  logic [LVL_W-1:0]   lvl;
  logic [ERR_W-1:0]   err_inc;
  logic [HIST_AW-1:0] idx_r;
  logic [HIST_CW-1:0] stab_r;
  logic               cmp_en_r;
  logic [LVL_W-1:0]   rd_lvl;
  logic               fault;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign lvl     = map_level(half_r, empty_r);
  assign err_inc = (err_r == ERR_SAT) ? err_r : err_r + ERR_W'(1);

  always_comb begin
    committed_nxt = committed_r;
    pend_lvl_nxt  = pend_lvl_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    rec_nxt       = rec_r;
    last_t_nxt    = last_t_r;
    pend_t_nxt    = pend_t_r;
    changed_nxt   = 1'b0;
    taken_nxt     = 1'b0;
    valid_nxt     = 1'b0;
    push          = 1'b0;
    if (op_r == OP_CLEAR) begin
      err_nxt = '0;
      rec_nxt = 1'b0;
    end else if ((now_r - last_t_r) >= TIME_W'(interval_r)) begin
      taken_nxt  = 1'b1;
      last_t_nxt = now_r;
      if (lvl == LVL_ERROR) begin
        err_nxt = err_inc;
        if (err_inc >= limit_r) begin
          rec_nxt       = 1'b1;
          committed_nxt = LVL_ERROR;
        end
      end else begin
        valid_nxt = 1'b1;
        push      = 1'b1;
        if (lvl != committed_r) begin
          if (!pend_r) begin
            pend_lvl_nxt = lvl;
            pend_nxt     = 1'b1;
            pend_t_nxt   = now_r;
          end else if (pend_lvl_r == lvl) begin
            if ((now_r - pend_t_r) >= TIME_W'(debounce_r)) begin
              committed_nxt = lvl;
              pend_nxt      = 1'b0;
              err_nxt       = '0;
              changed_nxt   = 1'b1;
            end
          end else begin
            pend_lvl_nxt = lvl;
            pend_t_nxt   = now_r;
          end
        end else begin
          pend_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (push) begin
      head_nxt = (head_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head_r + HIST_AW'(1);
      if (count_r < HIST_CW'(HIST_DEPTH)) begin
        count_nxt = count_r + HIST_CW'(1);
      end
    end
  end

  fsld_ram #(
    .WIDTH(LVL_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.update && push),
    .waddr(head_r),
    .wdata(lvl),
    .raddr(idx_r),
    .rdata(rd_lvl)
  );

  assign sts.walk_skip = (count_r < HIST_CW'(3));
  assign sts.walk_last = (idx_r == HIST_AW'(count_r - HIST_CW'(1)));

  assign fault = (committed_r == LVL_ERROR) || (err_r >= limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= RST_READ_INTERVAL;
      debounce_r  <= RST_DEBOUNCE;
      limit_r     <= RST_ERROR_LIMIT;
      committed_r <= LVL_ERROR;
      pend_lvl_r  <= LVL_ERROR;
      pend_r      <= 1'b0;
      err_r       <= '0;
      rec_r       <= 1'b0;
      last_t_r    <= '0;
      pend_t_r    <= '0;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      stab_r      <= '0;
      cmp_en_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_READ_INTERVAL: interval_r <= cfg_data;
          REG_DEBOUNCE:      debounce_r <= cfg_data;
          REG_ERROR_LIMIT:   limit_r    <= cfg_data[ERR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        committed_r <= committed_nxt;
        pend_lvl_r  <= pend_lvl_nxt;
        pend_r      <= pend_nxt;
        err_r       <= err_nxt;
        rec_r       <= rec_nxt;
        last_t_r    <= last_t_nxt;
        pend_t_r    <= pend_t_nxt;
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        idx_r       <= HIST_AW'(1);
        // Slot zero counts itself once enough entries are stored.
        stab_r      <= (count_nxt >= HIST_CW'(3)) ? HIST_CW'(1) : '0;
      end else if (cmd.walk_rd) begin
        idx_r <= idx_r + HIST_AW'(1);
      end
      cmp_en_r <= cmd.walk_rd;
      if (cmp_en_r && (rd_lvl == slot0_r)) begin
        stab_r <= stab_r + HIST_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_tuser;
      now_r   <= in_tdata[TIME_W-1:0];
      half_r  <= in_tdata[TIME_W];
      empty_r <= in_tdata[TIME_W+1];
    end
    if (cmd.update) begin
      changed_r <= changed_nxt;
      taken_r   <= taken_nxt;
      valid_r   <= valid_nxt;
      if (push && (head_r == '0)) begin
        slot0_r <= lvl;
      end
    end
    if (cmd.load_out) begin
      out_data_r <= {6'd0, pend_t_r, CNT_OUT_W'(count_r), CNT_OUT_W'(stab_r), err_r,
                     rec_r, fault, pend_r, valid_r, taken_r, changed_r, committed_r};
    end
  end

  assign out_tdata = out_data_r;

endmodule

// ----- src/float_switch_level_debouncer.sv -----
// Float switch level debouncer.
//
// Input channel (in_*): one item per handshake. in_tuser selects the operation
// (sample the switches or clear the error count and recovery latch); in_tdata
// carries the millisecond timestamp and both switch readings.
// Result channel (out_*): exactly one result item per input item, in order.
// Configuration (cfg_*): index 0 read interval, 1 debounce time, 2 error limit.
// cfg_ready is always high; write only while no item is in flight.
//
// An item is accepted only while the block is idle. It then passes the state
// update and, with three or more stored entries, walks the history ring one
// entry per cycle through the single read port of the history memory. The
// next item can be accepted only after the previous one has loaded its
// result. The result sits in an output register, so the next item is
// accepted while the previous result still waits; when out_tready stays low
// the block holds its finished result and stops before loading the next one.
// Reset sets the level to error, clears the counters, the pending and recovery
// flags and the history fill, and returns the configuration to its defaults.
module float_switch_level_debouncer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] now_ms, [32] half_wet, [33] empty_wet, [39:34] zero
  input  logic [fsld_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] operation
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [1:0] level, [2] level_changed, [3] sample_taken, [4] sample_valid,
  // [5] change_pending, [6] fault, [7] in_recovery, [15:8] error_total,
  // [20:16] stable_count, [25:21] history_fill, [57:26] change_time, [63:58] zero
  output logic [fsld_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fsld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsld_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import fsld_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fsld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsld_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

  // One item at a time: the block is busy right after an acceptance.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // The stability count never exceeds the number of stored entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[20:16] <= out_tdata[25:21]))
    else $error("stable_count exceeds history_fill");

  // A reported level change only happens on a taken, valid sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> (out_tdata[3] && out_tdata[4]))
    else $error("level change without a valid sample");

  // The error level always reports a fault.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == LVL_ERROR)) |-> out_tdata[6])
    else $error("error level without fault");

endmodule
